[rtl/bptc_pkg.sv]
// Shared types, constants and arithmetic helpers of the barometer compensation unit.
package bptc_pkg;

   localparam int FRACTION_BITS_DEFAULT = 20;
   localparam int DATA_W                = 64;
   localparam int RAW_W                 = 24;
   localparam int CAL_W                 = 48;
   localparam int TEMP_W                = 32;
   localparam int PRES_W                = 40;
   localparam int OUT_FRAC_BITS         = 8;
   localparam int LANES                 = 2;
   localparam int LANE_P                = 0;
   localparam int LANE_T                = 1;
   localparam int MUL_LAT               = 5;
   localparam int POLY_LAT              = 3 * MUL_LAT + 5;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_FIRST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_MIDDLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_LAST   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P_SCALE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_T_SCALE      = 3'd4;

   localparam logic [RAW_W-1:0] SCALE_RESET = 24'd253952;

   typedef logic signed [DATA_W-1:0] fix_type;

   localparam fix_type SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam fix_type SAT_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_out;
      logic signed [PRES_W-1:0] pressure_out;
   } rsp_type;

   // Coefficients already scaled to the fixed-point grid
   typedef struct packed {
      fix_type c0_half;
      fix_type c1;
      fix_type c00;
      fix_type c10;
      fix_type c01;
      fix_type c11;
      fix_type c20;
      fix_type c21;
      fix_type c30;
   } coef_type;

   function automatic fix_type sat_add(input fix_type a, input fix_type b);
      fix_type s;
      s = a + b;
      if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1]) begin
         sat_add = a[DATA_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_add = s;
      end
   endfunction

   // Clamp a magnitude to a signed field of the given width, return two's complement bits
   function automatic logic [DATA_W-1:0] out_clamp(input logic neg, input logic [DATA_W-1:0] m,
                                                   input int unsigned width);
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] sat;
      lim = 64'd1 << (width - 1);
      if (neg) begin
         sat = (m > lim) ? lim : m;
         out_clamp = -sat;
      end else begin
         sat = (m > lim - 64'd1) ? lim - 64'd1 : m;
         out_clamp = sat;
      end
   endfunction

endpackage

[rtl/baro_pressure_temp_compensation_unit.sv]
// An accepted req word passes through the one-bit-per-stage dividers and their sign fix,
//   the polynomial pipeline, the output conversion and the output register before rsp_valid.
// Throughput: one reading pair per cycle while req_stall is low; req_stall rises only while both the output
//   register and the skid register hold words.
// Reset: synchronous; clears all valid bits, calibration words to zero and both
//   scale registers to 253952.
module baro_pressure_temp_compensation_unit #(
   parameter int FRACTION_BITS = bptc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  bptc_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output bptc_pkg::rsp_type                rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bptc_pkg::CAL_W-1:0]       csr_wr_data
);
   import bptc_pkg::*;

   localparam int OUT_SHIFT = FRACTION_BITS - OUT_FRAC_BITS;

   logic [CAL_W-1:0] cal_first_ff, cal_middle_ff, cal_last_ff;
   logic [RAW_W-1:0] p_scale_ff, t_scale_ff;
   logic [RAW_W-1:0] div_p, div_t;
   coef_type         coef;

   logic adv;
   logic out_take;
   logic arrive;

   logic [LANES-1:0][RAW_W-1:0]  raw;
   logic [LANES-1:0][RAW_W-1:0]  divisor;
   logic [LANES-1:0][DATA_W-1:0] scaled;
   logic                         sc_valid;
   logic                         poly_valid;
   fix_type                      temp_v, pres_v;

   logic              oa_valid_ff;
   logic              t_neg_ff, p_neg_ff;
   logic [DATA_W-1:0] t_mag_ff, p_mag_ff;
   logic [DATA_W-1:0] t_mag_in, p_mag_in;
   logic [DATA_W-1:0] t_clamp, p_clamp;
   logic              fin_valid_ff;
   rsp_type           fin_data_ff;
   logic              rsp_valid_ff, skid_valid_ff;
   rsp_type           rsp_data_ff, skid_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_first_ff  <= '0;
         cal_middle_ff <= '0;
         cal_last_ff   <= '0;
         p_scale_ff    <= SCALE_RESET;
         t_scale_ff    <= SCALE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CALIB_FIRST:  cal_first_ff  <= csr_wr_data;
            CSR_CALIB_MIDDLE: cal_middle_ff <= csr_wr_data;
            CSR_CALIB_LAST:   cal_last_ff   <= csr_wr_data;
            CSR_P_SCALE:      p_scale_ff    <= csr_wr_data[RAW_W-1:0];
            CSR_T_SCALE:      t_scale_ff    <= csr_wr_data[RAW_W-1:0];
            default: ;
         endcase
      end
   end

   // a zero scale divides by one
   assign div_p = (p_scale_ff == '0) ? RAW_W'(1) : p_scale_ff;
   assign div_t = (t_scale_ff == '0) ? RAW_W'(1) : t_scale_ff;

   // unpack calibration bytes and move them onto the fixed-point grid
   assign coef.c0_half = {{52{cal_first_ff[47]}}, cal_first_ff[47:36]} << (FRACTION_BITS - 1);
   assign coef.c1  = {{52{cal_first_ff[35]}}, cal_first_ff[35:24]} << FRACTION_BITS;
   assign coef.c00 = {{44{cal_first_ff[23]}}, cal_first_ff[23:4]} << FRACTION_BITS;
   assign coef.c10 = {{44{cal_first_ff[3]}}, cal_first_ff[3:0], cal_middle_ff[47:32]}
                     << FRACTION_BITS;
   assign coef.c01 = {{48{cal_middle_ff[31]}}, cal_middle_ff[31:16]} << FRACTION_BITS;
   assign coef.c11 = {{48{cal_middle_ff[15]}}, cal_middle_ff[15:0]} << FRACTION_BITS;
   assign coef.c20 = {{48{cal_last_ff[47]}}, cal_last_ff[47:32]} << FRACTION_BITS;
   assign coef.c21 = {{48{cal_last_ff[31]}}, cal_last_ff[31:16]} << FRACTION_BITS;
   assign coef.c30 = {{48{cal_last_ff[15]}}, cal_last_ff[15:0]} << FRACTION_BITS;

   // the whole pipeline advances unless the skid register is occupied
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign raw[LANE_P]     = req_payload.raw_pressure;
   assign raw[LANE_T]     = req_payload.raw_temperature;
   assign divisor[LANE_P] = div_p;
   assign divisor[LANE_T] = div_t;

   bptc_scaler #(.FRACTION_BITS(FRACTION_BITS)) u_scaler (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .raw       (raw),
      .divisor   (divisor),
      .out_valid (sc_valid),
      .scaled    (scaled)
   );

   bptc_poly #(.FRACTION_BITS(FRACTION_BITS)) u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sc_valid),
      .p         (scaled[LANE_P]),
      .t         (scaled[LANE_T]),
      .coef      (coef),
      .out_valid (poly_valid),
      .temp      (temp_v),
      .pres      (pres_v)
   );

   // output conversion: magnitude and shift, then clamp and restore sign
   assign t_mag_in = temp_v[DATA_W-1] ? -temp_v : temp_v;
   assign p_mag_in = pres_v[DATA_W-1] ? -pres_v : pres_v;
   assign t_clamp  = out_clamp(t_neg_ff, t_mag_ff, TEMP_W);
   assign p_clamp  = out_clamp(p_neg_ff, p_mag_ff, PRES_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         oa_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         oa_valid_ff  <= poly_valid;
         fin_valid_ff <= oa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_neg_ff                    <= temp_v[DATA_W-1];
         p_neg_ff                    <= pres_v[DATA_W-1];
         t_mag_ff                    <= t_mag_in >> OUT_SHIFT;
         p_mag_ff                    <= p_mag_in >> OUT_SHIFT;
         fin_data_ff.temperature_out <= t_clamp[TEMP_W-1:0];
         fin_data_ff.pressure_out    <= p_clamp[PRES_W-1:0];
      end
   end

   // output register plus skid word
   assign out_take = rsp_valid_ff && !rsp_stall;
   assign arrive   = adv && fin_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= arrive;
         end
      end else if (arrive) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || out_take) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : fin_data_ff;
      end
      if (!skid_valid_ff) begin
         skid_data_ff <= fin_data_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held while output register is empty");

   a_frozen_holds: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && skid_valid_ff) |=> fin_valid_ff)
      else $error("pipeline word dropped while skid register was full");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en || csr_wr_en == 1'b0 |-> (div_p != '0 && div_t != '0))
      else $error("divider sees a zero divisor");

endmodule

[rtl/bptc_delay.sv]
// Enabled shift line that delays one fixed-point word by a set number of stages.
module bptc_delay #(
   parameter int DEPTH = 1
) (
   input  logic              clock,
   input  logic              en,
   input  bptc_pkg::fix_type din,
   output bptc_pkg::fix_type dout
);
   import bptc_pkg::*;

   fix_type tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

[rtl/bptc_scaler.sv]
// Pipelined restoring dividers that turn both raw readings into fixed-point values.
module bptc_scaler #(
   parameter int FRACTION_BITS = bptc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             en,
   input  logic                                             in_valid,
   input  logic [bptc_pkg::LANES-1:0][bptc_pkg::RAW_W-1:0]  raw,
   input  logic [bptc_pkg::LANES-1:0][bptc_pkg::RAW_W-1:0]  divisor,
   output logic                                             out_valid,
   output logic [bptc_pkg::LANES-1:0][bptc_pkg::DATA_W-1:0] scaled
);
   import bptc_pkg::*;

   localparam int QW = RAW_W + FRACTION_BITS;

   logic [QW:0] vld_ff;
   logic        out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[QW-1:0], in_valid};
         out_valid_ff <= vld_ff[QW];
      end
   end

   assign out_valid = out_valid_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic              neg_ff  [QW+1];
      logic [RAW_W-1:0]  rem_ff  [QW+1];
      logic [RAW_W-1:0]  num_ff  [QW+1];
      logic [QW-1:0]     quot_ff [QW+1];
      logic [RAW_W-1:0]  rem_in  [1:QW];
      logic              qbit_in [1:QW];
      logic [DATA_W-1:0] qext;
      logic [DATA_W-1:0] res_ff;

      // One quotient bit per stage: shift in the next dividend bit, subtract if it fits
      always_comb begin
         logic [RAW_W:0] cat;
         logic [RAW_W:0] diff;
         for (int s = 1; s <= QW; s++) begin
            cat        = {rem_ff[s-1], num_ff[s-1][RAW_W-1]};
            diff       = cat - {1'b0, divisor[l]};
            qbit_in[s] = (cat >= {1'b0, divisor[l]});
            rem_in[s]  = qbit_in[s] ? diff[RAW_W-1:0] : cat[RAW_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[0]  <= raw[l][RAW_W-1];
            num_ff[0]  <= raw[l][RAW_W-1] ? -raw[l] : raw[l];
            rem_ff[0]  <= '0;
            quot_ff[0] <= '0;
            for (int s = 1; s <= QW; s++) begin
               neg_ff[s]  <= neg_ff[s-1];
               num_ff[s]  <= {num_ff[s-1][RAW_W-2:0], 1'b0};
               rem_ff[s]  <= rem_in[s];
               quot_ff[s] <= {quot_ff[s-1][QW-2:0], qbit_in[s]};
            end
            res_ff <= neg_ff[QW] ? -qext : qext;
         end
      end

      assign qext      = {{(DATA_W-QW){1'b0}}, quot_ff[QW]};
      assign scaled[l] = res_ff;
   end

endmodule

[rtl/bptc_fixmul.sv]
// Five-stage saturating fixed-point multiply built from four 32x32 partial products.
module bptc_fixmul #(
   parameter int FRACTION_BITS = bptc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              en,
   input  bptc_pkg::fix_type a,
   input  bptc_pkg::fix_type b,
   output bptc_pkg::fix_type prod
);
   import bptc_pkg::*;

   localparam int HW = DATA_W / 2;

   logic              neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [DATA_W-1:0] x1_ff, y1_ff;
   logic [DATA_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [HW+1:0]     mid_ff;
   logic [DATA_W-1:0] hsum_ff;
   logic [HW-1:0]     lo_ff;
   logic [DATA_W-1:0] rlo_ff;
   logic              ovf_ff;
   fix_type           prod_ff;

   logic [DATA_W-1:0]   hi;
   logic [2*DATA_W-1:0] full;
   logic [2*DATA_W-1:0] shifted;

   assign hi      = hsum_ff + {{(DATA_W-2){1'b0}}, mid_ff[HW+1:HW]};
   assign full    = {hi, mid_ff[HW-1:0], lo_ff};
   assign shifted = full >> FRACTION_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         // magnitudes and sign
         neg1_ff <= a[DATA_W-1] ^ b[DATA_W-1];
         x1_ff   <= a[DATA_W-1] ? -a : a;
         y1_ff   <= b[DATA_W-1] ? -b : b;
         // partial products
         neg2_ff <= neg1_ff;
         ll_ff   <= x1_ff[HW-1:0]      * y1_ff[HW-1:0];
         lh_ff   <= x1_ff[HW-1:0]      * y1_ff[DATA_W-1:HW];
         hl_ff   <= x1_ff[DATA_W-1:HW] * y1_ff[HW-1:0];
         hh_ff   <= x1_ff[DATA_W-1:HW] * y1_ff[DATA_W-1:HW];
         // column sums
         neg3_ff <= neg2_ff;
         lo_ff   <= ll_ff[HW-1:0];
         mid_ff  <= (HW+2)'(ll_ff[DATA_W-1:HW]) + (HW+2)'(lh_ff[HW-1:0])
                    + (HW+2)'(hl_ff[HW-1:0]);
         hsum_ff <= hh_ff + DATA_W'(lh_ff[DATA_W-1:HW]) + DATA_W'(hl_ff[DATA_W-1:HW]);
         // drop the fraction bits
         neg4_ff <= neg3_ff;
         rlo_ff  <= shifted[DATA_W-1:0];
         ovf_ff  <= |shifted[2*DATA_W-1:DATA_W];
         // sign and saturate
         if (ovf_ff || rlo_ff[DATA_W-1]) begin
            prod_ff <= neg4_ff ? SAT_MIN : SAT_MAX;
         end else begin
            prod_ff <= neg4_ff ? -rlo_ff : rlo_ff;
         end
      end
   end

   assign prod = prod_ff;

endmodule

[rtl/bptc_poly.sv]
// Compensation polynomials for temperature and pressure as a scheduled multiply/add pipeline.
module bptc_poly #(
   parameter int FRACTION_BITS = bptc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  bptc_pkg::fix_type  p,
   input  bptc_pkg::fix_type  t,
   input  bptc_pkg::coef_type coef,
   output logic               out_valid,
   output bptc_pkg::fix_type  temp,
   output bptc_pkg::fix_type  pres
);
   import bptc_pkg::*;

   logic [POLY_LAT-1:0] vld_ff;

   fix_type mt, m1, m2, m3, m4, m5, m6, m7;
   fix_type p_d1, p_d2, m4_d, m6_d, m7_d, temp_d;
   fix_type temp_ff, inner1_ff, inner2_ff, cross_ff, pres1_ff, pres2_ff, pres3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[POLY_LAT-2:0], in_valid};
      end
   end

   // first wave: everything that needs only P, T and coefficients
   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_t1 (
      .clock(clock), .en(en), .a(coef.c1), .b(t), .prod(mt));
   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_p30 (
      .clock(clock), .en(en), .a(p), .b(coef.c30), .prod(m1));
   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_t01 (
      .clock(clock), .en(en), .a(t), .b(coef.c01), .prod(m4));
   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_p21 (
      .clock(clock), .en(en), .a(p), .b(coef.c21), .prod(m5));
   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_tp (
      .clock(clock), .en(en), .a(t), .b(p), .prod(m6));

   // align P with the Horner steps
   bptc_delay #(.DEPTH(MUL_LAT + 1)) u_dly_p1 (
      .clock(clock), .en(en), .din(p), .dout(p_d1));
   bptc_delay #(.DEPTH(MUL_LAT + 1)) u_dly_p2 (
      .clock(clock), .en(en), .din(p_d1), .dout(p_d2));

   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_h2 (
      .clock(clock), .en(en), .a(p_d1), .b(inner1_ff), .prod(m2));
   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_h3 (
      .clock(clock), .en(en), .a(p_d2), .b(inner2_ff), .prod(m3));

   bptc_delay #(.DEPTH(1)) u_dly_tp (
      .clock(clock), .en(en), .din(m6), .dout(m6_d));
   bptc_fixmul #(.FRACTION_BITS(FRACTION_BITS)) u_mul_cross (
      .clock(clock), .en(en), .a(m6_d), .b(cross_ff), .prod(m7));

   bptc_delay #(.DEPTH(2 * MUL_LAT + 3)) u_dly_t01 (
      .clock(clock), .en(en), .din(m4), .dout(m4_d));
   bptc_delay #(.DEPTH(MUL_LAT + 3)) u_dly_cross (
      .clock(clock), .en(en), .din(m7), .dout(m7_d));
   bptc_delay #(.DEPTH(2 * MUL_LAT + 4)) u_dly_temp (
      .clock(clock), .en(en), .din(temp_ff), .dout(temp_d));

   always_ff @(posedge clock) begin
      if (en) begin
         temp_ff   <= sat_add(coef.c0_half, mt);
         inner1_ff <= sat_add(coef.c20, m1);
         cross_ff  <= sat_add(coef.c11, m5);
         inner2_ff <= sat_add(coef.c10, m2);
         pres1_ff  <= sat_add(coef.c00, m3);
         pres2_ff  <= sat_add(pres1_ff, m4_d);
         pres3_ff  <= sat_add(pres2_ff, m7_d);
      end
   end

   assign out_valid = vld_ff[POLY_LAT-1];
   assign temp      = temp_d;
   assign pres      = pres3_ff;

endmodule
